// ===== design/gdc_pkg.sv =====
// gdc_pkg: shared types, constants and state encoding for the grid ray caster.
// No dependencies; imported by every module of the block except gdc_ram.
`timescale 1ns / 1ps
package gdc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int GRID_SIDE_DEF = 64;
    localparam int POS_W        = 22;
    localparam int INT_W        = POS_W - FRAC_BITS;
    localparam int VEC_W        = 18;
    localparam int SW_W         = 13;
    localparam int COL_W        = 12;
    localparam int DIST_W       = 24;
    localparam int CAM_NUM_W    = COL_W + 1 + FRAC_BITS;
    localparam int CAM_W        = CAM_NUM_W + 2;
    localparam int PROD_W       = VEC_W + CAM_W;
    localparam int RAY_W        = PROD_W - FRAC_BITS + 1;
    localparam int DIV_NUM_W    = 32;
    localparam int DIV_CNT_W    = 6;
    localparam int STEP_W       = 33;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 22;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam int RECIP_LIMIT  = 1 << (2 * FRAC_BITS - DIST_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_COLS    = 3'd0,
        CFG_POS_X        = 3'd1,
        CFG_POS_Y        = 3'd2,
        CFG_DIR_X        = 3'd3,
        CFG_DIR_Y        = 3'd4,
        CFG_PLANE_X      = 3'd5,
        CFG_PLANE_Y      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [SW_W-1:0]         view_cols;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] plane_x;
        logic signed [VEC_W-1:0] plane_y;
    } cfg_regs_t;

    typedef struct packed {
        logic             mode;
        logic [5:0]       cell_x;
        logic [5:0]       cell_y;
        logic             is_wall;
        logic [COL_W-1:0] column;
    } in_item_t;

    typedef struct packed {
        logic [5:0]        hit_x;
        logic [5:0]        hit_y;
        logic              hit_side;
        logic [DIST_W-1:0] wall_distance;
        logic              status;
    } out_item_t;

    typedef struct packed {
        logic             is_cast;
        logic             in_grid;
        logic [5:0]       cell_x;
        logic [5:0]       cell_y;
        logic             is_wall;
        logic [COL_W-1:0] column;
    } cmd_t;

    typedef struct packed {
        logic                  start;
        logic [RAY_W-1:0]      rem_init;
        logic [DIV_NUM_W-1:0]  num;
        logic [RAY_W-1:0]      divisor;
        logic [DIV_CNT_W-1:0]  iters;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] q;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_DIV,
        ST_MUL,
        ST_RAY,
        ST_DX_START,
        ST_DX_DIV,
        ST_DY_START,
        ST_DY_DIV,
        ST_FIRST,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ===== design/gdc_ram.sv =====
// gdc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/gdc_div.sv =====
// gdc_div: shared restoring divider, one quotient bit per cycle.
// Depends on gdc_pkg.
`timescale 1ns / 1ps
module gdc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  gdc_pkg::div_req_t req,
    output gdc_pkg::div_rsp_t rsp
);
    import gdc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [RAY_W-1:0]     rem_reg;
    logic [RAY_W-1:0]     d_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RAY_W:0]       rem2;
    logic                 fits;

    assign rem2 = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits = rem2 >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            d_reg   <= req.divisor;
            num_reg <= req.num;
            q_reg   <= '0;
            cnt_reg <= req.iters;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RAY_W'(rem2 - {1'b0, d_reg}) : rem2[RAY_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], fits};
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
endmodule

// ===== design/gdc_front.sv =====
// gdc_front: input acceptance, item decode and a two-entry command queue.
// Depends on gdc_pkg.
`timescale 1ns / 1ps
module gdc_front #(
    parameter int GRID_SIDE = gdc_pkg::GRID_SIDE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gdc_pkg::in_item_t in_data,
    input  logic              clearing,
    output logic              q_valid,
    input  logic              q_pop,
    output gdc_pkg::cmd_t     q_cmd
);
    import gdc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    cmd_t       cmd;

    assign in_stall = (count_reg == 2'd2) || clearing;
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = count_reg != 2'd0;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cmd.is_cast = in_data.mode;
        cmd.in_grid = (32'(in_data.cell_x) < GRID_SIDE) && (32'(in_data.cell_y) < GRID_SIDE);
        cmd.cell_x  = in_data.cell_x;
        cmd.cell_y  = in_data.cell_y;
        cmd.is_wall = in_data.is_wall;
        cmd.column  = in_data.column;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule

// ===== design/gdc_back.sv =====
// gdc_back: map clear and writes, ray setup, reciprocal deltas, DDA walk over the wall map, result register.
// Depends on gdc_pkg, gdc_div and gdc_ram.
`timescale 1ns / 1ps
module gdc_back #(
    parameter int GRID_SIDE = gdc_pkg::GRID_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gdc_pkg::cfg_regs_t cfg,
    output logic               clearing,
    input  logic               q_valid,
    output logic               q_pop,
    input  gdc_pkg::cmd_t      q_cmd,
    output logic               out_valid,
    input  logic               out_stall,
    output gdc_pkg::out_item_t out_data
);
    import gdc_pkg::*;

    localparam int LOG   = $clog2(GRID_SIDE);
    localparam int AW    = 2 * LOG;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = LOG + 2;
    localparam int LIMIT = 2 * GRID_SIDE + 2;
    localparam int KW    = $clog2(LIMIT + 1);
    localparam int ONE   = 1 << FRAC_BITS;

    state_t state_reg, state_next;

    logic [AW-1:0]             clr_cnt_reg;
    logic signed [CAM_W-1:0]   cam_reg;
    logic signed [PROD_W-1:0]  prodx_reg, prody_reg;
    logic [RAY_W-1:0]          absx_reg, absy_reg;
    logic                      negx_reg, negy_reg;
    logic [FRAC_BITS-1:0]      fx_reg, fy_reg;
    logic                      start_oob;
    logic [DIST_W-1:0]         dx_reg, dy_reg;
    logic [STEP_W-1:0]         sx_reg, sy_reg;
    logic signed [CW-1:0]      mx_reg, my_reg;
    logic                      side_reg;
    logic [KW-1:0]             k_reg;
    logic                      hit_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic                      ram_wdata, ram_rdata;

    logic signed [RAY_W-1:0]   rx, ry;
    logic                      big_x, big_y;
    logic                      step_y;
    logic signed [CW-1:0]      nmx, nmy;
    logic                      cur_oob;
    logic                      out_free;
    logic [FRAC_BITS:0]        ox, oy;
    logic [FRAC_BITS+DIST_W:0] mulx, muly;
    logic [STEP_W-1:0]         diff;
    logic [SW_W-1:0]           width_eff;

    gdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gdc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rx = RAY_W'(cfg.dir_x) + RAY_W'(prodx_reg >>> FRAC_BITS);
    assign ry = RAY_W'(cfg.dir_y) + RAY_W'(prody_reg >>> FRAC_BITS);
    assign big_x = absx_reg > RAY_W'(RECIP_LIMIT);
    assign big_y = absy_reg > RAY_W'(RECIP_LIMIT);
    assign step_y = !(sx_reg < sy_reg);
    assign nmx = step_y ? mx_reg : (negx_reg ? mx_reg - CW'(1) : mx_reg + CW'(1));
    assign nmy = !step_y ? my_reg : (negy_reg ? my_reg - CW'(1) : my_reg + CW'(1));
    assign cur_oob = (int'(mx_reg) < 0) || (int'(mx_reg) >= GRID_SIDE)
                  || (int'(my_reg) < 0) || (int'(my_reg) >= GRID_SIDE);
    assign out_free = !out_valid_reg || !out_stall;
    assign ox = negx_reg ? {1'b0, fx_reg} : (FRAC_BITS+1)'(ONE) - {1'b0, fx_reg};
    assign oy = negy_reg ? {1'b0, fy_reg} : (FRAC_BITS+1)'(ONE) - {1'b0, fy_reg};
    assign mulx = ox * dx_reg;
    assign muly = oy * dy_reg;
    assign diff = side_reg ? sy_reg - STEP_W'(dy_reg) : sx_reg - STEP_W'(dx_reg);
    assign width_eff = (cfg.view_cols == '0) ? SW_W'(1) : cfg.view_cols;
    assign ram_raddr = {nmy[LOG-1:0], nmx[LOG-1:0]};
    assign start_oob = (32'(cfg.pos_x[POS_W-1:FRAC_BITS]) >= GRID_SIDE)
                    || (32'(cfg.pos_y[POS_W-1:FRAC_BITS]) >= GRID_SIDE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    state_next = (&clr_cnt_reg) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:     state_next = (q_valid && q_cmd.is_cast) ? ST_CAM_DIV : ST_IDLE;
            ST_CAM_DIV:  state_next = div_rsp.done ? ST_MUL : ST_CAM_DIV;
            ST_MUL:      state_next = ST_RAY;
            ST_RAY:      state_next = start_oob ? ST_DONE : ST_DX_START;
            ST_DX_START: state_next = big_x ? ST_DX_DIV : ST_DY_START;
            ST_DX_DIV:   state_next = div_rsp.done ? ST_DY_START : ST_DX_DIV;
            ST_DY_START: state_next = big_y ? ST_DY_DIV : ST_FIRST;
            ST_DY_DIV:   state_next = div_rsp.done ? ST_FIRST : ST_DY_DIV;
            ST_FIRST:    state_next = ST_STEP;
            ST_STEP:     state_next = ST_CHECK;
            ST_CHECK:    state_next = (cur_oob || ram_rdata || k_reg == KW'(LIMIT))
                                      ? ST_DONE : ST_STEP;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clearing  = 1'b0;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = 1'b0;
        div_req   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                ram_we   = 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.is_cast)
                    begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.num      = {q_cmd.column, 1'b0, {FRAC_BITS{1'b0}},
                                            {(DIV_NUM_W-CAM_NUM_W){1'b0}}};
                        div_req.divisor  = RAY_W'(width_eff);
                        div_req.iters    = DIV_CNT_W'(CAM_NUM_W);
                    end
                    else if (q_cmd.in_grid)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = {LOG'(q_cmd.cell_y), LOG'(q_cmd.cell_x)};
                        ram_wdata = q_cmd.is_wall;
                    end
                end
            end
            ST_DX_START:
            begin
                div_req.start    = big_x;
                div_req.rem_init = RAY_W'(RECIP_LIMIT);
                div_req.num      = '0;
                div_req.divisor  = absx_reg;
                div_req.iters    = DIV_CNT_W'(DIST_W);
            end
            ST_DY_START:
            begin
                div_req.start    = big_y;
                div_req.rem_init = RAY_W'(RECIP_LIMIT);
                div_req.num      = '0;
                div_req.divisor  = absy_reg;
                div_req.iters    = DIV_CNT_W'(DIST_W);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                hit_reg <= 1'b0;
            end
            ST_CAM_DIV:
            begin
                cam_reg <= $signed({2'b00, div_rsp.q[CAM_NUM_W-1:0]}) - CAM_W'(ONE);
            end
            ST_MUL:
            begin
                prodx_reg <= cfg.plane_x * cam_reg;
                prody_reg <= cfg.plane_y * cam_reg;
            end
            ST_RAY:
            begin
                negx_reg <= rx[RAY_W-1];
                negy_reg <= ry[RAY_W-1];
                absx_reg <= rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
                absy_reg <= ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
                fx_reg   <= cfg.pos_x[FRAC_BITS-1:0];
                fy_reg   <= cfg.pos_y[FRAC_BITS-1:0];
                mx_reg   <= CW'($signed({1'b0, cfg.pos_x[POS_W-1:FRAC_BITS]}));
                my_reg   <= CW'($signed({1'b0, cfg.pos_y[POS_W-1:FRAC_BITS]}));
            end
            ST_DX_START:
            begin
                dx_reg <= DIST_MAX;
            end
            ST_DX_DIV:
            begin
                dx_reg <= div_rsp.q[DIST_W-1:0];
            end
            ST_DY_START:
            begin
                dy_reg <= DIST_MAX;
            end
            ST_DY_DIV:
            begin
                dy_reg <= div_rsp.q[DIST_W-1:0];
            end
            ST_FIRST:
            begin
                sx_reg <= STEP_W'(mulx >> FRAC_BITS);
                sy_reg <= STEP_W'(muly >> FRAC_BITS);
                k_reg  <= '0;
            end
            ST_STEP:
            begin
                if (step_y)
                begin
                    sy_reg <= sy_reg + STEP_W'(dy_reg);
                end
                else
                begin
                    sx_reg <= sx_reg + STEP_W'(dx_reg);
                end
                mx_reg   <= nmx;
                my_reg   <= nmy;
                side_reg <= step_y;
                k_reg    <= k_reg + KW'(1);
            end
            ST_CHECK:
            begin
                hit_reg <= !cur_oob && ram_rdata;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (hit_reg)
                    begin
                        out_data_reg.hit_x         <= 6'(32'(mx_reg));
                        out_data_reg.hit_y         <= 6'(32'(my_reg));
                        out_data_reg.hit_side      <= side_reg;
                        out_data_reg.wall_distance <= (diff > STEP_W'(DIST_MAX))
                                                      ? DIST_MAX : diff[DIST_W-1:0];
                        out_data_reg.status        <= 1'b0;
                    end
                    else
                    begin
                        out_data_reg        <= '0;
                        out_data_reg.status <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

// ===== design/grid_ray_dda_caster_core.sv =====
// Grid ray caster top: configuration registers, front queue and back engine.
// Depends on gdc_pkg, gdc_front, gdc_back.
// A write reaches the map when the back engine pops it from the queue; a cast gives its result
// after a camera divide, ray setup, a reciprocal divide per axis (skipped when saturated)
// and a DDA walk of up to 2*GRID_SIDE+2 cells. The back engine handles one item at a time.
// Reset: config to defaults; map swept clear with in_stall held high.
`timescale 1ns / 1ps
module grid_ray_dda_caster_core #(
    parameter int GRID_SIDE = gdc_pkg::GRID_SIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  gdc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output gdc_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gdc_pkg::*;

    cfg_regs_t cfg_reg;
    logic      clearing;
    logic      q_valid;
    logic      q_pop;
    cmd_t      q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_cols    <= SW_W'(640);
            cfg_reg.pos_x        <= POS_W'(163840);
            cfg_reg.pos_y        <= POS_W'(163840);
            cfg_reg.dir_x        <= -VEC_W'(65536);
            cfg_reg.dir_y        <= '0;
            cfg_reg.plane_x      <= '0;
            cfg_reg.plane_y      <= VEC_W'(43254);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VIEW_COLS:    cfg_reg.view_cols    <= cfg_data[SW_W-1:0];
                CFG_POS_X:        cfg_reg.pos_x        <= cfg_data[POS_W-1:0];
                CFG_POS_Y:        cfg_reg.pos_y        <= cfg_data[POS_W-1:0];
                CFG_DIR_X:        cfg_reg.dir_x        <= cfg_data[VEC_W-1:0];
                CFG_DIR_Y:        cfg_reg.dir_y        <= cfg_data[VEC_W-1:0];
                CFG_PLANE_X:      cfg_reg.plane_x      <= cfg_data[VEC_W-1:0];
                CFG_PLANE_Y:      cfg_reg.plane_y      <= cfg_data[VEC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gdc_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    gdc_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

// ===== dv/grid_ray_dda_caster_core_test.sv =====
// Self-checking testbench for grid_ray_dda_caster_core: grid writes and ray casts,
// checked against a bit-accurate DDA predictor. Depends on gdc_pkg and the core.
`timescale 1ns / 1ps
module grid_ray_dda_caster_core_test;
    import gdc_pkg::*;

    localparam int GS = 64;
    localparam longint DMAX = 64'd16777215;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #5 clk = ~clk;

    grid_ray_dda_caster_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    bit wall_map [GS*GS];
    logic [SW_W-1:0] m_sw;
    logic [POS_W-1:0] m_px, m_py;
    logic signed [VEC_W-1:0] m_dx, m_dy, m_plx, m_ply;

    out_item_t hit_queue [$];
    int errors = 0;
    int casts = 0;
    int writes = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint floor_sh(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint inv_len(input longint r);
        longint a, q;
        if (r == 0) return DMAX;
        a = (r < 0) ? -r : r;
        q = (64'd1 << 32) / a;
        return (q > DMAX) ? DMAX : q;
    endfunction

    function automatic out_item_t cast_ray(input logic [COL_W-1:0] col);
        out_item_t o;
        longint one, w, cam, rx, ry, mx, my, fx, fy, ddx, ddy, sx, sy, wall_dist;
        int stx, sty, side, k;
        bit hit;
        one = 64'd1 << FRAC_BITS;
        o = '0;
        o.status = 1'b1;
        side = 0;
        hit = 0;
        w = (m_sw == 0) ? 1 : longint'(m_sw);
        cam = ((2 * longint'(col)) << FRAC_BITS) / w - one;
        rx = longint'(m_dx) + floor_sh(longint'(m_plx) * cam);
        ry = longint'(m_dy) + floor_sh(longint'(m_ply) * cam);
        mx = longint'(m_px) >> FRAC_BITS;
        my = longint'(m_py) >> FRAC_BITS;
        if (mx >= GS || my >= GS) return o;
        fx = longint'(m_px) & (one - 1);
        fy = longint'(m_py) & (one - 1);
        ddx = inv_len(rx);
        ddy = inv_len(ry);
        if (rx < 0) begin stx = -1; sx = (fx * ddx) >> FRAC_BITS; end
        else begin stx = 1; sx = ((one - fx) * ddx) >> FRAC_BITS; end
        if (ry < 0) begin sty = -1; sy = (fy * ddy) >> FRAC_BITS; end
        else begin sty = 1; sy = ((one - fy) * ddy) >> FRAC_BITS; end
        for (k = 0; k < 2 * GS + 2; k++) begin
            if (sx < sy) begin sx += ddx; mx += stx; side = 0; end
            else begin sy += ddy; my += sty; side = 1; end
            if (mx < 0 || my < 0 || mx >= GS || my >= GS) break;
            if (wall_map[my * GS + mx]) begin hit = 1; break; end
        end
        if (!hit) return o;
        wall_dist = (side == 0) ? sx - ddx : sy - ddy;
        if (wall_dist > DMAX) wall_dist = DMAX;
        o.hit_x = mx[5:0];
        o.hit_y = my[5:0];
        o.hit_side = side[0];
        o.wall_distance = wall_dist[DIST_W-1:0];
        o.status = 1'b0;
        return o;
    endfunction

    task automatic model_config(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_VIEW_COLS: m_sw = v[SW_W-1:0];
            CFG_POS_X: m_px = v;
            CFG_POS_Y: m_py = v;
            CFG_DIR_X: m_dx = v[VEC_W-1:0];
            CFG_DIR_Y: m_dy = v[VEC_W-1:0];
            CFG_PLANE_X: m_plx = v[VEC_W-1:0];
            CFG_PLANE_Y: m_ply = v[VEC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_config(idx, v);
        @(posedge clk);
    endtask

    // send one transaction; optional typed-in expectation overrides predictor
    task automatic send_item(input in_item_t it, input bit use_fixed, input out_item_t fixed);
        out_item_t e;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        if (it.mode) begin
            e = cast_ray(it.column);
            if (use_fixed && e != fixed)
                report_mismatch("directed expectation disagrees with predictor");
            hit_queue.push_back(use_fixed ? fixed : e);
            casts++;
        end else begin
            wall_map[it.cell_y * GS + it.cell_x] = it.is_wall;
            writes++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // result checking
    always @(posedge clk) begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (hit_queue.size() == 0) begin
                report_mismatch("result transaction with none expected");
            end else begin
                e = hit_queue.pop_front();
                if (out_data.hit_x != e.hit_x)
                    report_mismatch($sformatf("hit_x %0d exp %0d", out_data.hit_x, e.hit_x));
                if (out_data.hit_y != e.hit_y)
                    report_mismatch($sformatf("hit_y %0d exp %0d", out_data.hit_y, e.hit_y));
                if (out_data.hit_side != e.hit_side)
                    report_mismatch($sformatf("hit_side %0d exp %0d",
                        out_data.hit_side, e.hit_side));
                if (out_data.wall_distance != e.wall_distance)
                    report_mismatch($sformatf("wall_distance %0d exp %0d",
                        out_data.wall_distance, e.wall_distance));
                if (out_data.status != e.status)
                    report_mismatch($sformatf("status %0d exp %0d",
                        out_data.status, e.status));
            end
        end
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic in_item_t mk_write(input int x, input int y, input bit wl);
        in_item_t it;
        it = '0;
        it.cell_x = 6'(x);
        it.cell_y = 6'(y);
        it.is_wall = wl;
        it.column = COL_W'($urandom_range(4095));
        return it;
    endfunction

    function automatic in_item_t mk_cast(input int col);
        in_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.cell_x = 6'($urandom_range(63));
        it.cell_y = 6'($urandom_range(63));
        it.is_wall = 1'($urandom_range(1));
        it.column = COL_W'(col);
        return it;
    endfunction

    typedef struct {
        in_item_t item;
        bit fixed;
        out_item_t result;
    } dir_row_t;

    localparam out_item_t LEFT_GRID = '{hit_x: 6'd0, hit_y: 6'd0, hit_side: 1'b0,
                                        wall_distance: 24'd0, status: 1'b1};

    task automatic random_phase(input int n);
        in_item_t it;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 40)
                it = mk_write($urandom_range(63), $urandom_range(63),
                              $urandom_range(99) < 35);
            else if ($urandom_range(9) == 0)
                it = mk_cast($urandom_range(4095));
            else
                it = mk_cast($urandom_range((m_sw == 0) ? 0 : m_sw - 1));
            send_item(it, 0, '0);
        end
    endtask

    task automatic random_view();
        write_reg(CFG_VIEW_COLS, CFG_DATA_W'($urandom_range(1, 4096)));
        write_reg(CFG_POS_X,
                  CFG_DATA_W'(($urandom_range(1, 62) << 16) | $urandom_range(65535)));
        write_reg(CFG_POS_Y,
                  CFG_DATA_W'(($urandom_range(1, 62) << 16) | $urandom_range(65535)));
        write_reg(CFG_DIR_X, CFG_DATA_W'($urandom_range(262143)));
        write_reg(CFG_DIR_Y, CFG_DATA_W'($urandom_range(262143)));
        write_reg(CFG_PLANE_X, CFG_DATA_W'($urandom_range(262143)));
        write_reg(CFG_PLANE_Y, CFG_DATA_W'($urandom_range(262143)));
    endtask

    initial begin
        dir_row_t rows [$];
        dir_row_t r;
        m_sw = 640; m_px = 163840; m_py = 163840;
        m_dx = -18'sd65536; m_dy = 0; m_plx = 0; m_ply = 43254;
        foreach (wall_map[i]) wall_map[i] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty map after reset: every ray leaves the grid
        r = '{mk_cast(0), 1, LEFT_GRID}; rows.push_back(r);
        r = '{mk_cast(639), 1, LEFT_GRID}; rows.push_back(r);
        r = '{mk_cast(4095), 1, LEFT_GRID}; rows.push_back(r);
        // border walls
        for (int i = 0; i < 64; i += 63) begin
            r = '{mk_write(0, 2, 1), 0, '0}; rows.push_back(r);
        end
        r = '{mk_write(63, 63, 1), 0, '0}; rows.push_back(r);
        r = '{mk_write(0, 0, 1), 0, '0}; rows.push_back(r);
        r = '{mk_cast(320), 0, '0}; rows.push_back(r);
        r = '{mk_cast(0), 0, '0}; rows.push_back(r);
        r = '{mk_cast(639), 0, '0}; rows.push_back(r);
        r = '{mk_write(0, 2, 0), 0, '0}; rows.push_back(r);
        r = '{mk_cast(320), 0, '0}; rows.push_back(r);
        r = '{mk_write(1, 2, 1), 0, '0}; rows.push_back(r);
        r = '{mk_cast(320), 0, '0}; rows.push_back(r);
        r = '{mk_cast(2047), 0, '0}; rows.push_back(r);
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].result);
        drain();

        // zero-width screen, zero ray components, ties at exact diagonals
        write_reg(CFG_VIEW_COLS, CFG_DATA_W'(0));
        write_reg(CFG_PLANE_Y, CFG_DATA_W'(0));
        write_reg(CFG_DIR_X, CFG_DATA_W'(0));
        write_reg(CFG_DIR_Y, CFG_DATA_W'(18'h1FFFF));
        write_reg(CFG_PLANE_X, CFG_DATA_W'(18'h20000));
        send_item(mk_write(2, 10, 1), 0, '0);
        send_item(mk_cast(0), 0, '0);
        send_item(mk_cast(4095), 0, '0);
        drain();
        write_reg(CFG_DIR_X, CFG_DATA_W'(65536));
        write_reg(CFG_DIR_Y, CFG_DATA_W'(65536));
        write_reg(CFG_PLANE_X, CFG_DATA_W'(0));
        write_reg(CFG_POS_X, CFG_DATA_W'(32768));
        write_reg(CFG_POS_Y, CFG_DATA_W'(32768));
        send_item(mk_write(5, 5, 1), 0, '0);
        send_item(mk_cast(1), 0, '0);
        drain();
        // start in the last cell: the first step leaves the grid
        write_reg(CFG_POS_X, CFG_DATA_W'(22'h3FFFFF));
        send_item(mk_cast(0), 1, LEFT_GRID);
        drain();
        write_reg(CFG_POS_X, CFG_DATA_W'(0));
        write_reg(CFG_POS_Y, CFG_DATA_W'(22'h3FFFFF));
        send_item(mk_cast(0), 1, LEFT_GRID);
        drain();
        write_reg(CFG_VIEW_COLS, CFG_DATA_W'(4096));
        write_reg(CFG_POS_Y, CFG_DATA_W'(0));
        write_reg(CFG_DIR_Y, CFG_DATA_W'(18'h20000));
        write_reg(CFG_PLANE_Y, CFG_DATA_W'(18'h1FFFF));
        send_item(mk_cast(4095), 0, '0);
        send_item(mk_cast(2048), 0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin in_idle_pct = 0; out_stall_pct = 0; end
                1: begin in_idle_pct = 69; out_stall_pct = 0; end
                2: begin in_idle_pct = 0; out_stall_pct = 69; end
                default: begin in_idle_pct = 37; out_stall_pct = 37; end
            endcase
            random_view();
            random_phase(175);
            drain();
        end

        $display("Covered %0d grid writes and %0d ray casts over 8 random views", writes, casts);
        $display("with idle and stall mixes on both channels; %0d mismatches", errors);
        if (errors == 0 && hit_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
